### rtl/amau_pkg.sv
// Package with the request and result types and the mode codes of the address unit.
`timescale 1ns / 1ps
`default_nettype none

package amau_pkg;

	typedef enum logic [4:0] {
		MODE_ABS_X_IND  = 5'd0,
		MODE_ABS_IND    = 5'd1,
		MODE_ABS_IND_L  = 5'd2,
		MODE_ABS        = 5'd3,
		MODE_ABS_X      = 5'd4,
		MODE_ABS_Y      = 5'd5,
		MODE_LONG_X     = 5'd6,
		MODE_DP         = 5'd7,
		MODE_DP_IND     = 5'd8,
		MODE_DP_IND_L   = 5'd9,
		MODE_DP_X       = 5'd10,
		MODE_DP_X_IND   = 5'd11,
		MODE_DP_Y       = 5'd12,
		MODE_DP_IND_Y   = 5'd13,
		MODE_DP_IND_L_Y = 5'd14,
		MODE_REL8       = 5'd15,
		MODE_REL16      = 5'd16,
		MODE_LONG       = 5'd17,
		MODE_IMM        = 5'd18,
		MODE_SR         = 5'd19,
		MODE_SR_IND_Y   = 5'd20
	} mode_t;

	localparam logic [1:0] PLEN_NONE = 2'd0;
	localparam logic [1:0] PLEN_WORD = 2'd2;
	localparam logic [1:0] PLEN_LONG = 2'd3;

	typedef struct packed {
		logic [4:0]  operation;
		logic [23:0] operand_bytes;
		logic [15:0] program_counter;
		logic [7:0]  program_bank;
		logic [7:0]  data_bank;
		logic [15:0] direct_base;
		logic [15:0] index_x;
		logic [15:0] index_y;
		logic [15:0] stack_ptr;
		logic        emulation_mode;
		logic [23:0] pointer_data;
	} req_t;

	typedef struct packed {
		logic [23:0] pointer_location;
		logic [1:0]  pointer_length;
		logic        pointer_page_wrap;
		logic [23:0] effective_address;
	} rsp_t;

endpackage

`default_nettype wire

### rtl/amau_if.sv
// Valid/ready channel interfaces for address requests and address results.
`timescale 1ns / 1ps
`default_nettype none

interface amau_req_if;
	logic            valid;
	logic            ready;
	amau_pkg::req_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface amau_rsp_if;
	logic            valid;
	logic            ready;
	amau_pkg::rsp_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/amau_calc.sv
// Combinational address calculation for one registered request.
`timescale 1ns / 1ps
`default_nettype none

module amau_calc (
	input  wire amau_pkg::req_t req,
	output amau_pkg::rsp_t      rsp
);
	import amau_pkg::*;

	logic [7:0]  op8;
	logic [15:0] op16;
	logic        pagemode;
	logic [15:0] dsum;
	logic [7:0]  dpage_sum;
	logic [7:0]  dpage_x;
	logic [7:0]  dpage_y;
	logic [15:0] dfull_x;
	logic [15:0] dfull_y;
	logic [23:0] dp_x_addr;
	logic [23:0] dp_y_addr;
	logic [23:0] ind_y;
	logic [15:0] sp_sum;

	assign op8       = req.operand_bytes[7:0];
	assign op16      = req.operand_bytes[15:0];
	assign pagemode  = req.emulation_mode && (req.direct_base[7:0] == 8'h00);
	assign dsum      = req.direct_base + {8'h00, op8};
	assign dpage_sum = req.direct_base[7:0] + op8;
	assign dpage_x   = req.direct_base[7:0] + op8 + req.index_x[7:0];
	assign dpage_y   = req.direct_base[7:0] + op8 + req.index_y[7:0];
	assign dfull_x   = dsum + req.index_x;
	assign dfull_y   = dsum + req.index_y;
	assign dp_x_addr = pagemode ? {8'h00, req.direct_base[15:8], dpage_x} : {8'h00, dfull_x};
	assign dp_y_addr = pagemode ? {8'h00, req.direct_base[15:8], dpage_y} : {8'h00, dfull_y};
	assign ind_y     = {req.data_bank, req.pointer_data[15:0]} + {8'h00, req.index_y};
	assign sp_sum    = req.stack_ptr + {8'h00, op8};

	always_comb begin
		rsp = '0;
		case (mode_t'(req.operation))
			MODE_ABS_X_IND: begin
				rsp.pointer_location  = {req.program_bank, op16 + req.index_x};
				rsp.pointer_length    = PLEN_WORD;
				rsp.effective_address = {8'h00, req.pointer_data[15:0]};
			end
			MODE_ABS_IND: begin
				rsp.pointer_location  = {8'h00, op16};
				rsp.pointer_length    = PLEN_WORD;
				rsp.effective_address = {8'h00, req.pointer_data[15:0]};
			end
			MODE_ABS_IND_L: begin
				rsp.pointer_location  = {8'h00, op16};
				rsp.pointer_length    = PLEN_LONG;
				rsp.effective_address = req.pointer_data;
			end
			MODE_ABS: begin
				rsp.effective_address = {req.data_bank, op16};
			end
			MODE_ABS_X: begin
				rsp.effective_address = {req.data_bank, op16} + {8'h00, req.index_x};
			end
			MODE_ABS_Y: begin
				rsp.effective_address = {req.data_bank, op16} + {8'h00, req.index_y};
			end
			MODE_LONG_X: begin
				rsp.effective_address = req.operand_bytes + {8'h00, req.index_x};
			end
			MODE_DP: begin
				rsp.effective_address = {8'h00, dsum};
			end
			MODE_DP_IND: begin
				rsp.pointer_location  = pagemode ?
					{8'h00, req.direct_base[15:8], dpage_sum} : {8'h00, dsum};
				rsp.pointer_length    = PLEN_WORD;
				rsp.pointer_page_wrap = pagemode;
				rsp.effective_address = {req.data_bank, req.pointer_data[15:0]};
			end
			MODE_DP_IND_L: begin
				rsp.pointer_location  = {8'h00, dsum};
				rsp.pointer_length    = PLEN_LONG;
				rsp.effective_address = req.pointer_data;
			end
			MODE_DP_X: begin
				rsp.effective_address = dp_x_addr;
			end
			MODE_DP_X_IND: begin
				rsp.pointer_location  = dp_x_addr;
				rsp.pointer_length    = PLEN_WORD;
				rsp.pointer_page_wrap = pagemode;
				rsp.effective_address = {req.data_bank, req.pointer_data[15:0]};
			end
			MODE_DP_Y: begin
				rsp.effective_address = dp_y_addr;
			end
			MODE_DP_IND_Y: begin
				rsp.pointer_location  = {8'h00, dsum};
				rsp.pointer_length    = PLEN_WORD;
				rsp.pointer_page_wrap = pagemode;
				rsp.effective_address = ind_y;
			end
			MODE_DP_IND_L_Y: begin
				rsp.pointer_location  = {8'h00, dsum};
				rsp.pointer_length    = PLEN_LONG;
				rsp.effective_address = req.pointer_data + {8'h00, req.index_y};
			end
			MODE_REL8: begin
				rsp.effective_address = {req.program_bank,
					req.program_counter + 16'd2 + {{8{op8[7]}}, op8}};
			end
			MODE_REL16: begin
				rsp.effective_address = {req.program_bank, req.program_counter + 16'd3 + op16};
			end
			MODE_LONG: begin
				rsp.effective_address = req.operand_bytes;
			end
			MODE_IMM: begin
				rsp.effective_address = {req.program_bank, req.program_counter + 16'd1};
			end
			MODE_SR: begin
				rsp.effective_address = {8'h00, sp_sum};
			end
			MODE_SR_IND_Y: begin
				rsp.pointer_location  = {8'h00, sp_sum};
				rsp.pointer_length    = PLEN_WORD;
				rsp.effective_address = ind_y;
			end
			default: begin
				rsp = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

### rtl/addressing_mode_address_unit.sv
// Top level of the effective address unit: input register, address logic, result register.
`timescale 1ns / 1ps
`default_nettype none

// The unit takes one addressing request per clock unless stalled, and presents its pointer
// location, pointer length, pointer wrap rule and effective address on the result channel
// once it has passed both registers. Each request is captured in an input register,
// the address is formed in one pass of adders and selection, and the result waits in an
// output register until it is taken. A request is accepted in every cycle unless a result
// is stalled on the output and a request waits behind it in the input register, so a
// stalled result holds at most the two requests already inside.

module addressing_mode_address_unit (
	input  wire           clk,
	input  wire           arst_n,
	amau_req_if.sink      req,
	amau_rsp_if.source    rsp
);
	import amau_pkg::*;

	logic  valid_s1;
	logic  valid_s2;
	req_t  data_s1;
	rsp_t  data_s2;
	rsp_t  calc_rsp;
	logic  load_s1;
	logic  load_s2;

	assign load_s2   = !valid_s2 || rsp.ready;
	assign load_s1   = !valid_s1 || load_s2;
	assign req.ready = load_s1;
	assign rsp.valid = valid_s2;
	assign rsp.data  = data_s2;

	amau_calc u_calc (
		.req (data_s1),
		.rsp (calc_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= req.valid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && req.valid) begin
			data_s1 <= req.data;
		end
		if (load_s2 && valid_s1) begin
			data_s2 <= calc_rsp;
		end
	end

endmodule

`default_nettype wire

### rtl/amau_check.sv
// Port-level assertions for the address unit and the bind that attaches them.
`timescale 1ns / 1ps
`default_nettype none

module amau_check (
	input wire            clk,
	input wire            arst_n,
	input wire            req_valid,
	input wire            req_ready,
	input wire            rsp_valid,
	input wire            rsp_ready,
	input amau_pkg::rsp_t rsp_data
);
	import amau_pkg::*;

	// A stalled result keeps its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result changed while stalled");

	// The unit only refuses a request while its result side is blocked.
	assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid && !rsp_ready)
		else $error("request refused without a stalled result");

	// An accepted request is followed by a valid result on the output.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |-> ##2 rsp_valid)
		else $error("no result two cycles after an accepted request");

	// Page wrap is only reported for two-byte pointers.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.pointer_page_wrap |-> rsp_data.pointer_length == PLEN_WORD)
		else $error("page wrap reported without a two-byte pointer");

	// Pointer lengths are none, two or three bytes.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.pointer_length != 2'd1)
		else $error("illegal pointer length");

endmodule

bind addressing_mode_address_unit amau_check u_amau_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

`default_nettype wire

### tb/addressing_mode_address_unit_tb.sv
// Self-checking testbench for the effective address unit with a built-in predictor.
`timescale 1ns / 1ps

module addressing_mode_address_unit_tb;
	import amau_pkg::*;

	localparam logic [4:0] MODE_UNDEF_FIRST = 5'd21;
	localparam logic [4:0] MODE_UNDEF_LAST = 5'd31;
	localparam int RANDOM_REQUESTS = 550;
	localparam int IDLE_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 8;

	class address_checker;
		rsp_t expected_addresses[$];
		int mismatches = 0;

		static function rsp_t compute_address(req_t r);
			rsp_t res;
			logic [7:0] op8;
			logic [15:0] op16;
			logic [15:0] ptr16;
			logic [15:0] dsum;
			logic [15:0] xsum;
			logic [15:0] ysum;
			logic [15:0] ssum;
			logic [15:0] pc_target;
			logic pagemode;
			res = '0;
			op8 = r.operand_bytes[7:0];
			op16 = r.operand_bytes[15:0];
			ptr16 = r.pointer_data[15:0];
			pagemode = r.emulation_mode && (r.direct_base[7:0] == 8'h00);
			dsum = r.direct_base + {8'h00, op8};
			xsum = r.direct_base + {8'h00, op8} + r.index_x;
			ysum = r.direct_base + {8'h00, op8} + r.index_y;
			ssum = r.stack_ptr + {8'h00, op8};
			pc_target = '0;
			case (r.operation)
				MODE_ABS_X_IND: begin
					res.pointer_location = {r.program_bank, 16'(op16 + r.index_x)};
					res.pointer_length = PLEN_WORD;
					res.effective_address = {8'h00, ptr16};
				end
				MODE_ABS_IND: begin
					res.pointer_location = {8'h00, op16};
					res.pointer_length = PLEN_WORD;
					res.effective_address = {8'h00, ptr16};
				end
				MODE_ABS_IND_L: begin
					res.pointer_location = {8'h00, op16};
					res.pointer_length = PLEN_LONG;
					res.effective_address = r.pointer_data;
				end
				MODE_ABS: res.effective_address = {r.data_bank, op16};
				MODE_ABS_X: res.effective_address = {r.data_bank, op16} + {8'h00, r.index_x};
				MODE_ABS_Y: res.effective_address = {r.data_bank, op16} + {8'h00, r.index_y};
				MODE_LONG_X: res.effective_address = r.operand_bytes + {8'h00, r.index_x};
				MODE_DP: res.effective_address = {8'h00, dsum};
				MODE_DP_IND: begin
					res.pointer_location = pagemode ?
						{8'h00, r.direct_base[15:8], dsum[7:0]} : {8'h00, dsum};
					res.pointer_length = PLEN_WORD;
					res.pointer_page_wrap = pagemode;
					res.effective_address = {r.data_bank, ptr16};
				end
				MODE_DP_IND_L: begin
					res.pointer_location = {8'h00, dsum};
					res.pointer_length = PLEN_LONG;
					res.effective_address = r.pointer_data;
				end
				MODE_DP_X: res.effective_address = pagemode ?
					{8'h00, r.direct_base[15:8], xsum[7:0]} : {8'h00, xsum};
				MODE_DP_X_IND: begin
					res.pointer_location = pagemode ?
						{8'h00, r.direct_base[15:8], xsum[7:0]} : {8'h00, xsum};
					res.pointer_length = PLEN_WORD;
					res.pointer_page_wrap = pagemode;
					res.effective_address = {r.data_bank, ptr16};
				end
				MODE_DP_Y: res.effective_address = pagemode ?
					{8'h00, r.direct_base[15:8], ysum[7:0]} : {8'h00, ysum};
				MODE_DP_IND_Y: begin
					res.pointer_location = {8'h00, dsum};
					res.pointer_length = PLEN_WORD;
					res.pointer_page_wrap = pagemode;
					res.effective_address = {r.data_bank, ptr16} + {8'h00, r.index_y};
				end
				MODE_DP_IND_L_Y: begin
					res.pointer_location = {8'h00, dsum};
					res.pointer_length = PLEN_LONG;
					res.effective_address = r.pointer_data + {8'h00, r.index_y};
				end
				MODE_REL8: begin
					pc_target = r.program_counter + 16'd2 + {{8{op8[7]}}, op8};
					res.effective_address = {r.program_bank, pc_target};
				end
				MODE_REL16: begin
					pc_target = r.program_counter + 16'd3 + op16;
					res.effective_address = {r.program_bank, pc_target};
				end
				MODE_LONG: res.effective_address = r.operand_bytes;
				MODE_IMM: begin
					pc_target = r.program_counter + 16'd1;
					res.effective_address = {r.program_bank, pc_target};
				end
				MODE_SR: res.effective_address = {8'h00, ssum};
				MODE_SR_IND_Y: begin
					res.pointer_location = {8'h00, ssum};
					res.pointer_length = PLEN_WORD;
					res.effective_address = {r.data_bank, ptr16} + {8'h00, r.index_y};
				end
				default: res = '0;
			endcase
			return res;
		endfunction

		function void note_request(req_t r);
			expected_addresses.push_back(compute_address(r));
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (expected_addresses.size() == 0) begin
				if (mismatches < 10)
					$display("Result with no request pending: loc %h len %0d wrap %0d addr %h",
						got.pointer_location, got.pointer_length, got.pointer_page_wrap,
						got.effective_address);
				mismatches++;
				return;
			end
			want = expected_addresses.pop_front();
			if (got.pointer_location !== want.pointer_location ||
				got.pointer_length !== want.pointer_length ||
				got.pointer_page_wrap !== want.pointer_page_wrap ||
				got.effective_address !== want.effective_address) begin
				if (mismatches < 10)
					$display({"Mismatch: expected loc %h len %0d wrap %0d addr %h, ",
						"got loc %h len %0d wrap %0d addr %h"},
						want.pointer_location, want.pointer_length, want.pointer_page_wrap,
						want.effective_address, got.pointer_location, got.pointer_length,
						got.pointer_page_wrap, got.effective_address);
				mismatches++;
			end
		endfunction

		function int pending();
			return expected_addresses.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int burst_left;
	address_checker tracker = new;

	amau_req_if req_ch();
	amau_rsp_if rsp_ch();

	addressing_mode_address_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [23:0] pick_value(int bits);
		logic [23:0] mask;
		logic [23:0] value;
		mask = (24'h1 << bits) - 24'h1;
		case ($urandom_range(0, 7))
			0: value = '0;
			1: value = '1;
			default: value = 24'($urandom);
		endcase
		return value & mask;
	endfunction

	function automatic req_t random_request();
		req_t r;
		if ($urandom_range(0, 11) == 0)
			r.operation = 5'($urandom_range(MODE_UNDEF_FIRST, MODE_UNDEF_LAST));
		else
			r.operation = 5'($urandom_range(MODE_ABS_X_IND, MODE_SR_IND_Y));
		r.operand_bytes = pick_value(24);
		r.program_counter = 16'(pick_value(16));
		r.program_bank = 8'(pick_value(8));
		r.data_bank = 8'(pick_value(8));
		r.direct_base = 16'(pick_value(16));
		if ($urandom_range(0, 2) == 0)
			r.direct_base[7:0] = 8'h00;
		r.index_x = 16'(pick_value(16));
		r.index_y = 16'(pick_value(16));
		r.stack_ptr = 16'(pick_value(16));
		r.emulation_mode = 1'($urandom);
		r.pointer_data = pick_value(24);
		return r;
	endfunction

	task automatic send_request(input req_t r);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		req_ch.valid <= 1'b1;
		req_ch.data <= r;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	task automatic run_directed_requests();
		req_t r;
		int m;
		for (m = MODE_ABS_X_IND; m <= MODE_SR_IND_Y; m++) begin
			if (m % 2) begin
				r = '1;
			end else begin
				r = '0;
				r.emulation_mode = 1'b1;
				r.direct_base = 16'hff00;
				r.index_x = '1;
				r.index_y = '1;
			end
			r.operation = 5'(m);
			send_request(r);
		end
		// Indexed indirect pointer in emulation page mode, wrapping inside the page.
		r = '0;
		r.operation = MODE_DP_X_IND;
		r.emulation_mode = 1'b1;
		r.direct_base = 16'h3400;
		r.operand_bytes = 24'h0000f0;
		r.index_x = 16'h0123;
		r.pointer_data = 24'h89abcd;
		send_request(r);
		// Forward branch that wraps inside the program bank.
		r = '0;
		r.operation = MODE_REL8;
		r.program_counter = 16'hfffd;
		r.program_bank = 8'h5a;
		r.operand_bytes = 24'h00007f;
		send_request(r);
		r = '1;
		r.operation = MODE_UNDEF_FIRST;
		send_request(r);
		r.operation = MODE_UNDEF_LAST;
		send_request(r);
	endtask

	always @(posedge clk) begin
		if (req_ch.valid && req_ch.ready)
			tracker.note_request(req_ch.data);
		if (rsp_ch.valid && rsp_ch.ready)
			tracker.check_result(rsp_ch.data);
	end

	initial begin
		int style;
		int span;
		rsp_ch.ready = 1'b0;
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			style = $urandom_range(0, 3);
			span = $urandom_range(4, 48);
			repeat (span) begin
				@(posedge clk);
				case (style)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= 1'($urandom);
					2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
					default: rsp_ch.ready <= 1'b0;
				endcase
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (arst_n !== 1'b1) @(posedge clk);
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("addressing_mode_address_unit_tb NOT OK");
		$finish;
	end

	initial begin
		int n;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		burst_left = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		run_directed_requests();
		for (n = 0; n < RANDOM_REQUESTS; n++)
			send_request(random_request());
		req_ch.valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("addressing_mode_address_unit_tb OK");
		else
			$display("addressing_mode_address_unit_tb NOT OK");
		$finish;
	end

endmodule
